>>> hw/rtl/ypfc_pkg.sv
// Package for the yaw/pitch fly camera: fixed-point formats, opcodes,
// register indexes, sequencer states, the arctangent table and rounding helpers.
// No dependencies.
package ypfc_pkg;

  localparam int CORDIC_STEPS       = 16;
  localparam int VECTOR_FRAC_BITS   = 14;
  localparam int POSITION_FRAC_BITS = 16;
  localparam int CORDIC_ITERS       = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int MOVE_SHIFT         = 16 + VECTOR_FRAC_BITS - POSITION_FRAC_BITS;

  // Angles in Q16.16 degrees
  localparam logic signed [25:0] DEG_90    = 26'sd5898240;
  localparam logic signed [25:0] DEG_180   = 26'sd11796480;
  localparam logic        [35:0] DEG_360   = 36'd23592960;
  // 180 degrees plus 128 turns keeps any look sum positive before reduction
  localparam logic        [35:0] WRAP_BIAS = 36'd3031695360;
  localparam logic signed [33:0] GAIN_Q30  = 34'sd652032874;

  localparam logic signed [17:0] VEC_UNIT = 18'sd1 <<< VECTOR_FRAC_BITS;
  localparam logic signed [17:0] VEC_ONE  =
    (VECTOR_FRAC_BITS > 14) ? 18'sd32767 : VEC_UNIT;

  typedef enum logic [2:0] {
    OP_FWD   = 3'd0,
    OP_BACK  = 3'd1,
    OP_LEFT  = 3'd2,
    OP_RIGHT = 3'd3,
    OP_UP    = 3'd4,
    OP_DOWN  = 3'd5,
    OP_LOOK  = 3'd6,
    OP_HOME  = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    REG_MOVE_SPEED  = 3'd0,
    REG_LOOK_SENS   = 3'd1,
    REG_PITCH_LIMIT = 3'd2,
    REG_HOME_X      = 3'd3,
    REG_HOME_Y      = 3'd4,
    REG_HOME_Z      = 3'd5,
    REG_HOME_YAW    = 3'd6,
    REG_HOME_PITCH  = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEL,
    ST_VLAT,
    ST_MOVE,
    ST_ANG_X,
    ST_ANG_Y,
    ST_ANG_P,
    ST_HOME,
    ST_WRAP,
    ST_CSET,
    ST_CORDIC,
    ST_PROD,
    ST_DONE
  } st_e;

  // atan(2^-i) in Q16.16 degrees
  function automatic logic signed [25:0] atan_deg(input logic [4:0] i);
    logic signed [25:0] a;
    unique case (i)
      5'd0:  a = 26'sd2949120;
      5'd1:  a = 26'sd1740967;
      5'd2:  a = 26'sd919879;
      5'd3:  a = 26'sd466945;
      5'd4:  a = 26'sd234379;
      5'd5:  a = 26'sd117304;
      5'd6:  a = 26'sd58666;
      5'd7:  a = 26'sd29335;
      5'd8:  a = 26'sd14668;
      5'd9:  a = 26'sd7334;
      5'd10: a = 26'sd3667;
      5'd11: a = 26'sd1833;
      5'd12: a = 26'sd917;
      5'd13: a = 26'sd458;
      5'd14: a = 26'sd229;
      5'd15: a = 26'sd115;
      5'd16: a = 26'sd57;
      5'd17: a = 26'sd29;
      5'd18: a = 26'sd14;
      5'd19: a = 26'sd7;
      5'd20: a = 26'sd4;
      5'd21: a = 26'sd2;
      5'd22: a = 26'sd1;
      default: a = 26'sd0;
    endcase
    return a;
  endfunction

  // Round to nearest (ties up) from frac fraction bits, clamp to +-one
  function automatic logic signed [15:0] vec_round(input logic signed [65:0] v,
                                                   input int unsigned frac);
    logic signed [65:0] r;
    r = (v + (66'sd1 <<< (frac - VECTOR_FRAC_BITS - 1))) >>> (frac - VECTOR_FRAC_BITS);
    if (r > 66'(VEC_ONE)) begin
      r = 66'(VEC_ONE);
    end else if (r < -66'(VEC_ONE)) begin
      r = -66'(VEC_ONE);
    end
    return r[15:0];
  endfunction

endpackage

>>> hw/rtl/yaw_pitch_fly_camera.sv
// Fly camera pose keeper: position, yaw, pitch and the front/right/up basis.
// One shared multiplier and one shared CORDIC add/shift stage under a sequencer.
// Depends on ypfc_pkg.
//
// Usage: one beat on the slave stream carries an opcode in tuser (move forward,
// back, left, right, up, down, look, recenter) and delta time and mouse offsets
// in tdata. Each beat gives exactly one master beat with the position and the
// nine basis components. Registers are written through cfg_we_i/cfg_idx_i/
// cfg_data_i; the user must write them only while no beat is in flight, and
// the block does not enforce it. A look or recenter runs two CORDIC passes,
// yaw then pitch, one step per cycle on the shared rotation stage; a move
// takes one multiply per component on the shared multiplier.
// One item at a time: tready is high only while the sequencer is idle.
// Reset loads the register defaults, the pose at the origin with zero angles
// and the basis front +x, right +z, up +y; no result is pending.
// A result held by a stalled receiver stays in the output register while the
// next item is accepted and worked; that item then waits for the register.
module yaw_pitch_fly_camera
  import ypfc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // step_time [15:0], mouse_dx [31:16], mouse_dy [47:32]
  input  logic [47:0]   s_axis_tdata_i,
  // opcode [2:0]
  input  logic [2:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // pos_x, pos_y, pos_z (32 each), front_x..z, right_x..z, up_x..z (16 each)
  output logic [239:0]  m_axis_tdata_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i
);

  st_e                st_q, st_d;
  logic [4:0]         cnt_q, cnt_d;
  logic               pass_q, pass_d;

  // registers
  logic [15:0]        speed_q, sens_q;
  logic [22:0]        plim_q;
  logic signed [31:0] home_q [3];
  logic signed [24:0] hyaw_q;
  logic signed [23:0] hpitch_q;

  // pose
  logic signed [31:0] pos_q [3];
  logic signed [24:0] yaw_q;
  logic signed [23:0] pitch_q;
  logic signed [15:0] basis_q [9];

  // work payload
  op_e                op_q;
  logic [15:0]        dt_q;
  logic signed [15:0] xo_q, yo_q;
  logic signed [65:0] prod_q;
  logic [31:0]        vel_q;
  logic [35:0]        wrap_q;
  logic signed [33:0] x_q, y_q;
  logic signed [25:0] z_q;
  logic               neg_q;
  logic signed [31:0] cy_q, sy_q, cp_q, sp_q;

  logic               out_valid_q;
  logic [239:0]       out_data_q;

  logic               in_fire, out_free;
  logic signed [32:0] mul_a, mul_b;
  logic signed [17:0] comp;
  logic [3:0]         comp_idx;
  logic [1:0]         mv_k;
  logic signed [65:0] mv_d, mv_sum;
  logic signed [31:0] mv_sat;
  logic [35:0]        wrap_sub, wrap_nx;
  logic [23:0]        lim;
  logic signed [25:0] ang, ang_adj;
  logic               ang_neg;
  logic signed [33:0] x_nx, y_nx;
  logic signed [25:0] z_nx;
  logic signed [35:0] pitch_look, pitch_home;

  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Clamp pitch to the limit, never beyond 90 degrees
  assign lim = ({1'b0, plim_q} > 24'(DEG_90)) ? 24'(DEG_90) : {1'b0, plim_q};

  function automatic logic signed [23:0] clamp_pitch(input logic signed [35:0] v,
                                                     input logic [23:0] l);
    logic signed [35:0] r;
    r = v;
    if (r > $signed({12'b0, l})) begin
      r = $signed({12'b0, l});
    end else if (r < -$signed({12'b0, l})) begin
      r = -$signed({12'b0, l});
    end
    return r[23:0];
  endfunction

  assign pitch_look = $signed(36'(pitch_q) + prod_q[35:0]);
  assign pitch_home = 36'(hpitch_q);

  // Direction component for the move in flight
  always_comb begin
    comp_idx = {2'b00, cnt_q[1:0]};
    comp     = 18'sd0;
    unique case (op_q)
      OP_FWD, OP_BACK:   comp = 18'(basis_q[comp_idx]);
      OP_LEFT, OP_RIGHT: comp = 18'(basis_q[comp_idx + 4'd3]);
      OP_UP, OP_DOWN:    comp = (cnt_q[1:0] == 2'd1) ? VEC_UNIT : 18'sd0;
      default:           comp = 18'sd0;
    endcase
    if (op_q == OP_BACK || op_q == OP_LEFT || op_q == OP_DOWN) begin
      comp = -comp;
    end
  end

  // Round the displacement and add it with saturation
  assign mv_k   = cnt_q[1:0] - 2'd1;
  assign mv_d   = (prod_q + (66'sd1 <<< (MOVE_SHIFT - 1))) >>> MOVE_SHIFT;
  assign mv_sum = 66'(pos_q[mv_k]) + mv_d;
  always_comb begin
    if (mv_sum > 66'sd2147483647) begin
      mv_sat = 32'sh7fffffff;
    end else if (mv_sum < -66'sd2147483648) begin
      mv_sat = 32'sh80000000;
    end else begin
      mv_sat = mv_sum[31:0];
    end
  end

  // Yaw reduction: one conditional subtract of 360 * 2^k per cycle
  assign wrap_sub = DEG_360 << cnt_q[2:0];
  assign wrap_nx  = (wrap_q >= wrap_sub) ? wrap_q - wrap_sub : wrap_q;

  // Fold the CORDIC angle into [-90, 90]
  always_comb begin
    ang     = pass_q ? 26'(pitch_q) : 26'(yaw_q);
    ang_adj = ang;
    ang_neg = 1'b0;
    if (ang > DEG_90) begin
      ang_adj = ang - DEG_180;
      ang_neg = 1'b1;
    end else if (ang < -DEG_90) begin
      ang_adj = ang + DEG_180;
      ang_neg = 1'b1;
    end
  end

  // Shared CORDIC rotation stage
  always_comb begin
    if (!z_q[25]) begin
      x_nx = x_q - (y_q >>> cnt_q);
      y_nx = y_q + (x_q >>> cnt_q);
      z_nx = z_q - atan_deg(cnt_q);
    end else begin
      x_nx = x_q + (y_q >>> cnt_q);
      y_nx = y_q - (x_q >>> cnt_q);
      z_nx = z_q + atan_deg(cnt_q);
    end
  end

  // Sequencer and shared multiplier operands
  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    pass_d = pass_q;
    mul_a  = 33'sd0;
    mul_b  = 33'sd0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (op_e'(s_axis_tuser_i))
            OP_LOOK: st_d = ST_ANG_X;
            OP_HOME: st_d = ST_HOME;
            default: st_d = ST_VEL;
          endcase
        end
      end
      ST_VEL: begin
        mul_a = $signed({17'b0, speed_q});
        mul_b = $signed({17'b0, dt_q});
        st_d  = ST_VLAT;
      end
      ST_VLAT: begin
        st_d  = ST_MOVE;
        cnt_d = 5'd0;
      end
      ST_MOVE: begin
        mul_a = $signed({1'b0, vel_q});
        mul_b = 33'(comp);
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd3) begin
          st_d = ST_DONE;
        end
      end
      ST_ANG_X: begin
        mul_a = 33'(xo_q);
        mul_b = $signed({17'b0, sens_q});
        st_d  = ST_ANG_Y;
      end
      ST_ANG_Y: begin
        mul_a = 33'(yo_q);
        mul_b = $signed({17'b0, sens_q});
        st_d  = ST_ANG_P;
      end
      ST_ANG_P, ST_HOME: begin
        st_d  = ST_WRAP;
        cnt_d = 5'd7;
      end
      ST_WRAP: begin
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          st_d   = ST_CSET;
          pass_d = 1'b0;
        end
      end
      ST_CSET: begin
        st_d  = ST_CORDIC;
        cnt_d = 5'd0;
      end
      ST_CORDIC: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(CORDIC_ITERS - 1)) begin
          if (!pass_q) begin
            st_d   = ST_CSET;
            pass_d = 1'b1;
          end else begin
            st_d  = ST_PROD;
            cnt_d = 5'd0;
          end
        end
      end
      ST_PROD: begin
        unique case (cnt_q[1:0])
          2'd0: begin mul_a = 33'(cy_q); mul_b = 33'(cp_q); end
          2'd1: begin mul_a = 33'(sy_q); mul_b = 33'(cp_q); end
          2'd2: begin mul_a = 33'(cy_q); mul_b = 33'(sp_q); end
          default: begin mul_a = 33'(sy_q); mul_b = 33'(sp_q); end
        endcase
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd4) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cnt_q  <= 5'd0;
      pass_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      pass_q <= pass_d;
    end
  end

  // Registers, pose and output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q     <= 16'd80;
      sens_q      <= 16'd6554;
      plim_q      <= 23'd5832704;
      home_q[0]   <= '0;
      home_q[1]   <= '0;
      home_q[2]   <= '0;
      hyaw_q      <= '0;
      hpitch_q    <= '0;
      pos_q[0]    <= '0;
      pos_q[1]    <= '0;
      pos_q[2]    <= '0;
      yaw_q       <= '0;
      pitch_q     <= '0;
      for (int i = 0; i < 9; i++) begin
        basis_q[i] <= '0;
      end
      basis_q[0]  <= 16'(VEC_ONE);
      basis_q[5]  <= 16'(VEC_ONE);
      basis_q[7]  <= 16'(VEC_ONE);
      out_valid_q <= 1'b0;
    end else begin
      // take register writes
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_MOVE_SPEED:  speed_q   <= cfg_data_i[15:0];
          REG_LOOK_SENS:   sens_q    <= cfg_data_i[15:0];
          REG_PITCH_LIMIT: plim_q    <= cfg_data_i[22:0];
          REG_HOME_X:      home_q[0] <= cfg_data_i;
          REG_HOME_Y:      home_q[1] <= cfg_data_i;
          REG_HOME_Z:      home_q[2] <= cfg_data_i;
          REG_HOME_YAW:    hyaw_q    <= cfg_data_i[24:0];
          REG_HOME_PITCH:  hpitch_q  <= cfg_data_i[23:0];
          default: ;
        endcase
      end

      // raise the beat when the item is done, drop it once taken
      if (st_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (st_q)
        ST_MOVE: begin
          if (cnt_q != 5'd0) begin
            pos_q[mv_k] <= mv_sat;
          end
        end
        ST_ANG_P: pitch_q <= clamp_pitch(pitch_look, lim);
        ST_HOME: begin
          pos_q[0] <= home_q[0];
          pos_q[1] <= home_q[1];
          pos_q[2] <= home_q[2];
          pitch_q  <= clamp_pitch(pitch_home, lim);
        end
        ST_WRAP: begin
          if (cnt_q == 5'd0) begin
            yaw_q <= 25'(wrap_nx - 36'(DEG_180));
          end
        end
        ST_PROD: begin
          unique case (cnt_q[2:0])
            3'd0: begin
              basis_q[1] <= vec_round(66'(sp_q), 30);
              basis_q[3] <= vec_round(-66'(sy_q), 30);
              basis_q[4] <= '0;
              basis_q[5] <= vec_round(66'(cy_q), 30);
              basis_q[7] <= vec_round(66'(cp_q), 30);
            end
            3'd1: basis_q[0] <= vec_round(prod_q, 60);
            3'd2: basis_q[2] <= vec_round(prod_q, 60);
            3'd3: basis_q[6] <= vec_round(-prod_q, 60);
            3'd4: basis_q[8] <= vec_round(-prod_q, 60);
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Work payload: item fields, product, yaw reduction, CORDIC, output data
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_fire) begin
      op_q <= op_e'(s_axis_tuser_i);
      dt_q <= s_axis_tdata_i[15:0];
      xo_q <= s_axis_tdata_i[31:16];
      yo_q <= s_axis_tdata_i[47:32];
    end
    unique case (st_q)
      ST_VLAT: vel_q  <= prod_q[31:0];
      ST_ANG_Y: wrap_q <= 36'(yaw_q) + prod_q[35:0] + WRAP_BIAS;
      ST_HOME: wrap_q <= 36'(hyaw_q) + WRAP_BIAS;
      ST_WRAP: wrap_q <= wrap_nx;
      ST_CSET: begin
        x_q   <= GAIN_Q30;
        y_q   <= '0;
        z_q   <= ang_adj;
        neg_q <= ang_neg;
      end
      ST_CORDIC: begin
        x_q <= x_nx;
        y_q <= y_nx;
        z_q <= z_nx;
        if (cnt_q == 5'(CORDIC_ITERS - 1)) begin
          if (!pass_q) begin
            cy_q <= neg_q ? -x_nx[31:0] : x_nx[31:0];
            sy_q <= neg_q ? -y_nx[31:0] : y_nx[31:0];
          end else begin
            cp_q <= neg_q ? -x_nx[31:0] : x_nx[31:0];
            sp_q <= neg_q ? -y_nx[31:0] : y_nx[31:0];
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_q <= {basis_q[8], basis_q[7], basis_q[6], basis_q[5], basis_q[4],
                         basis_q[3], basis_q[2], basis_q[1], basis_q[0],
                         pos_q[2], pos_q[1], pos_q[0]};
        end
      end
      default: ;
    endcase
  end

  // Checks on the sequencer and the pose
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("ready held high after an accepted beat");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pitch_q <= 24'(DEG_90)) && (pitch_q >= -24'(DEG_90)))
    else $error("pitch beyond 90 degrees");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> ((yaw_q >= -25'(DEG_180)) && (yaw_q < 25'(DEG_180))))
    else $error("yaw outside [-180,180) while idle");

  a_right_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    basis_q[4] == 16'sd0)
    else $error("right vector has a vertical component");

  a_result_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DONE && out_free) |=> (out_valid_q && st_q == ST_IDLE))
    else $error("finished item did not reach the output register");

endmodule
